[design/lwkd_pkg.sv]
// ----------------------------------------------------------------------------
// lwkd_pkg
// Shared types and constants for the longest k-distinct byte window block.
// ----------------------------------------------------------------------------
package lwkd_pkg;

  localparam int MAX_LEN  = 4096;
  localparam int ALPHABET = 256;

  localparam int BYTE_W  = 8;
  localparam int POS_W   = $clog2(MAX_LEN + 1);
  localparam int CNT_W   = POS_W;
  localparam int K_W     = $clog2(ALPHABET + 1);
  localparam int HIST_AW = $clog2(MAX_LEN);
  localparam int SYM_AW  = $clog2(ALPHABET);

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register index, taken from paddr[2]
  localparam logic REG_DISTINCT_LIMIT = 1'b0;
  localparam logic REG_EXACT_MODE     = 1'b1;

  localparam logic [K_W-1:0] DISTINCT_LIMIT_RST = K_W'(1);
  localparam logic           EXACT_MODE_RST     = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic              last_byte;
    logic              drop;
  } item_t;

  typedef struct packed {
    logic [K_W-1:0] distinct_limit;
    logic           exact_mode;
  } cfg_t;

endpackage

[design/longest_window_k_distinct_bytes.sv]
// ----------------------------------------------------------------------------
// longest_window_k_distinct_bytes
// Streams a byte string and reports the longest window with k distinct bytes (exactly k, or at most k).
// ----------------------------------------------------------------------------
// Each accepted byte passes through the engine's S_ISSUE and S_UPDATE states:
// S_ISSUE reads the per-byte count table (current byte and window-start byte)
// and writes the history buffer, then S_UPDATE updates counts, window and best
// length. The count table's read-modify-write keeps the engine from taking a
// new byte before the last one is through S_UPDATE. Bytes past 4096 in one
// string are ignored and are discarded in S_ISSUE with no S_UPDATE step. A two
// entry queue buffers input bytes, so push sees full only when the engine
// falls behind. The result of a string is registered in S_UPDATE of its last
// byte, or in S_ISSUE when that byte is past the length limit, after any bytes
// still queued ahead of it. The result stays on the result ports until popped;
// while it waits, the engine keeps taking the next string's bytes and stalls
// only at that string's last byte. At the end of a string the counts are
// invalidated at once through their valid bits: there is no clearing pass.
// ----------------------------------------------------------------------------
module longest_window_k_distinct_bytes (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic [lwkd_pkg::BYTE_W-1:0]        in_byte_value,
  input  logic                               in_last_byte,
  output logic                               empty,
  input  logic                               pop,
  output logic [lwkd_pkg::POS_W-1:0]         out_best_length,
  output logic                               out_none_found,
  output logic                               out_too_long,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lwkd_pkg::APB_AW-1:0]        paddr,
  input  logic [lwkd_pkg::APB_DW-1:0]        pwdata,
  output logic [lwkd_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);

  lwkd_pkg::cfg_t  cfg_r;
  lwkd_pkg::item_t q_in;
  lwkd_pkg::item_t q_head;
  logic            q_wr;
  logic            q_full;
  logic            q_rd;
  logic            q_empty;
  logic            res_valid;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.distinct_limit <= lwkd_pkg::DISTINCT_LIMIT_RST;
      cfg_r.exact_mode     <= lwkd_pkg::EXACT_MODE_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        lwkd_pkg::REG_DISTINCT_LIMIT: cfg_r.distinct_limit <= pwdata[lwkd_pkg::K_W-1:0];
        lwkd_pkg::REG_EXACT_MODE:     cfg_r.exact_mode     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      lwkd_pkg::REG_DISTINCT_LIMIT: prdata = lwkd_pkg::APB_DW'(cfg_r.distinct_limit);
      lwkd_pkg::REG_EXACT_MODE:     prdata = lwkd_pkg::APB_DW'(cfg_r.exact_mode);
      default:                      prdata = '0;
    endcase
  end

  lwkd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_byte_value (in_byte_value),
    .in_last_byte  (in_last_byte),
    .q_full        (q_full),
    .q_wr          (q_wr),
    .q_item        (q_in)
  );

  lwkd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_item (q_in),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_item (q_head),
    .empty   (q_empty)
  );

  lwkd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_rd            (q_rd),
    .res_valid       (res_valid),
    .res_pop         (pop),
    .res_best_length (out_best_length),
    .res_none_found  (out_none_found),
    .res_too_long    (out_too_long)
  );

  assign empty = !res_valid;

  a_rd_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |-> !q_empty)
    else $error("engine read from an empty queue");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_none_found) |-> (out_best_length == '0))
    else $error("none_found with a nonzero length");

  a_none_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_none_found) |-> cfg_r.exact_mode)
    else $error("none_found outside exact mode");

endmodule

[design/lwkd_front.sv]
// ----------------------------------------------------------------------------
// lwkd_front
// Accepts input bytes, marks bytes past the length limit, feeds the queue.
// ----------------------------------------------------------------------------
module lwkd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [lwkd_pkg::BYTE_W-1:0] in_byte_value,
  input  logic                        in_last_byte,
  input  logic                        q_full,
  output logic                        q_wr,
  output lwkd_pkg::item_t             q_item
);

  logic [lwkd_pkg::POS_W-1:0] len_r;
  logic [lwkd_pkg::POS_W-1:0] len_nxt;
  logic                       at_limit;

  assign full     = q_full;
  assign q_wr     = push && !q_full;
  assign at_limit = (len_r == lwkd_pkg::POS_W'(lwkd_pkg::MAX_LEN));

  assign q_item.byte_value = in_byte_value;
  assign q_item.last_byte  = in_last_byte;
  assign q_item.drop       = at_limit;

  always_comb begin
    len_nxt = len_r;
    if (q_wr) begin
      if (in_last_byte) begin
        len_nxt = '0;
      end else if (!at_limit) begin
        len_nxt = len_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

endmodule

[design/lwkd_queue.sv]
// ----------------------------------------------------------------------------
// lwkd_queue
// Two-entry queue between the front classifier and the back engine.
// ----------------------------------------------------------------------------
module lwkd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  lwkd_pkg::item_t wr_item,
  output logic            full,
  input  logic            rd_en,
  output lwkd_pkg::item_t rd_item,
  output logic            empty
);

  lwkd_pkg::item_t               slot_r [lwkd_pkg::Q_DEPTH];
  logic [lwkd_pkg::Q_AW-1:0]     wr_ptr_r;
  logic [lwkd_pkg::Q_AW-1:0]     rd_ptr_r;
  logic [lwkd_pkg::Q_CW-1:0]     cnt_r;
  logic [lwkd_pkg::Q_CW-1:0]     cnt_nxt;
  logic                          do_wr;
  logic                          do_rd;

  assign full    = (cnt_r == lwkd_pkg::Q_CW'(lwkd_pkg::Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

[design/lwkd_back.sv]
// ----------------------------------------------------------------------------
// lwkd_back
// Window engine: count table and history updates, best length, result slot.
// ----------------------------------------------------------------------------
module lwkd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lwkd_pkg::cfg_t              cfg,
  input  logic                        q_empty,
  input  lwkd_pkg::item_t             q_head,
  output logic                        q_rd,
  output logic                        res_valid,
  input  logic                        res_pop,
  output logic [lwkd_pkg::POS_W-1:0]  res_best_length,
  output logic                        res_none_found,
  output logic                        res_too_long
);

  typedef enum logic {
    S_ISSUE,
    S_UPDATE
  } state_t;

  localparam int CW = lwkd_pkg::CNT_W;
  localparam int PW = lwkd_pkg::POS_W;
  localparam int KW = lwkd_pkg::K_W;
  localparam int BW = lwkd_pkg::BYTE_W;

  logic [CW-1:0] cnt_mem  [lwkd_pkg::ALPHABET];
  logic [BW-1:0] hist_mem [lwkd_pkg::MAX_LEN];

  state_t                  state_r;
  lwkd_pkg::item_t         cur_r;
  logic [KW-1:0]           dist_r;
  logic [PW-1:0]           ws_r;
  logic [PW-1:0]           pos_r;
  logic [PW-1:0]           best_r;
  logic                    ovf_r;
  logic [BW-1:0]           old_r;
  logic [lwkd_pkg::ALPHABET-1:0] vld_r;
  logic [CW-1:0]           rd0_r;
  logic [CW-1:0]           rd1_r;
  logic                    vld0_r;
  logic                    vld1_r;
  logic [BW-1:0]           hist_rd_r;
  logic                    fwd0_r;
  logic                    fwd1_r;
  logic [CW-1:0]           fwd_d_r;
  logic                    pend_v_r;
  logic [BW-1:0]           pend_a_r;
  logic [CW-1:0]           pend_d_r;
  logic                    out_v_r;
  logic [PW-1:0]           out_best_r;
  logic                    out_none_r;
  logic                    out_tl_r;

  logic          can_out;
  logic          issue;
  logic          take_real;
  logic          take_drop;
  logic          upd;
  logic [BW-1:0] v;
  logic [BW-1:0] old;
  logic          same;
  logic [CW-1:0] cv;
  logic [CW-1:0] cv_new;
  logic [KW-1:0] dist1;
  logic [KW-1:0] dist2;
  logic          leave;
  logic [CW-1:0] co;
  logic [CW-1:0] co_new;
  logic          dec;
  logic [PW-1:0] ws2;
  logic [PW-1:0] pos1;
  logic [PW-1:0] len;
  logic          qual;
  logic [PW-1:0] best2;
  logic          none2;
  logic [CW-1:0] wr_data;

  function automatic logic [lwkd_pkg::HIST_AW-1:0] ws2_pf();
    logic [PW-1:0] nx;
    nx = ws_r + 1'b1;
    return nx[lwkd_pkg::HIST_AW-1:0];
  endfunction

  assign can_out   = !out_v_r || res_pop;
  assign issue     = (state_r == S_ISSUE) && !q_empty && (!q_head.last_byte || can_out);
  assign take_real = issue && !q_head.drop;
  assign take_drop = issue && q_head.drop;
  assign q_rd      = issue;
  assign upd       = (state_r == S_UPDATE);

  assign v    = cur_r.byte_value;
  assign same = (ws_r == pos_r);
  assign old  = same ? v : old_r;

  always_comb begin
    cv     = fwd0_r ? fwd_d_r : (vld0_r ? rd0_r : '0);
    cv_new = cv + 1'b1;
    dist1  = dist_r + KW'(cv == '0);
    leave  = (dist1 > cfg.distinct_limit);
    if (old == v) begin
      co = cv_new;
    end else begin
      co = fwd1_r ? fwd_d_r : (vld1_r ? rd1_r : '0);
    end
    dec    = leave && (co != '0);
    co_new = co - 1'b1;
    dist2  = dist1 - KW'(dec && (co_new == '0));
    ws2    = ws_r + PW'(leave);
    pos1   = pos_r + 1'b1;
    len    = pos1 - ws2;
    qual   = cfg.exact_mode ? (dist2 == cfg.distinct_limit) : (dist2 <= cfg.distinct_limit);
    best2  = (qual && (len > best_r)) ? len : best_r;
    none2  = cfg.exact_mode && (best2 == '0);
    wr_data = (dec && (old == v)) ? co_new : cv_new;
  end

  assign res_valid       = out_v_r;
  assign res_best_length = out_best_r;
  assign res_none_found  = out_none_r;
  assign res_too_long    = out_tl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_ISSUE;
      cur_r      <= '0;
      dist_r     <= '0;
      ws_r       <= '0;
      pos_r      <= '0;
      best_r     <= '0;
      ovf_r      <= 1'b0;
      old_r      <= '0;
      vld_r      <= '0;
      vld0_r     <= 1'b0;
      vld1_r     <= 1'b0;
      fwd0_r     <= 1'b0;
      fwd1_r     <= 1'b0;
      fwd_d_r    <= '0;
      pend_v_r   <= 1'b0;
      pend_a_r   <= '0;
      pend_d_r   <= '0;
      out_v_r    <= 1'b0;
      out_best_r <= '0;
      out_none_r <= 1'b0;
      out_tl_r   <= 1'b0;
    end else begin
      pend_v_r <= 1'b0;
      if (pend_v_r) begin
        vld_r[pend_a_r] <= 1'b1;
      end
      if (res_pop && out_v_r) begin
        out_v_r <= 1'b0;
      end

      case (state_r)
        S_ISSUE: begin
          if (take_real) begin
            cur_r   <= q_head;
            vld0_r  <= vld_r[q_head.byte_value];
            vld1_r  <= vld_r[old_r];
            fwd0_r  <= pend_v_r && (pend_a_r == q_head.byte_value);
            fwd1_r  <= pend_v_r && (pend_a_r == old_r);
            fwd_d_r <= pend_d_r;
            state_r <= S_UPDATE;
          end else if (take_drop) begin
            if (q_head.last_byte) begin
              out_v_r    <= 1'b1;
              out_none_r <= cfg.exact_mode && (best_r == '0);
              out_best_r <= (cfg.exact_mode && (best_r == '0)) ? '0 : best_r;
              out_tl_r   <= 1'b1;
              dist_r     <= '0;
              ws_r       <= '0;
              pos_r      <= '0;
              best_r     <= '0;
              ovf_r      <= 1'b0;
              vld_r      <= '0;
            end else begin
              ovf_r <= 1'b1;
            end
          end
        end
        S_UPDATE: begin
          state_r <= S_ISSUE;
          if (cur_r.last_byte) begin
            out_v_r    <= 1'b1;
            out_none_r <= none2;
            out_best_r <= none2 ? '0 : best2;
            out_tl_r   <= ovf_r;
            dist_r     <= '0;
            ws_r       <= '0;
            pos_r      <= '0;
            best_r     <= '0;
            ovf_r      <= 1'b0;
            vld_r      <= '0;
          end else begin
            dist_r   <= dist2;
            ws_r     <= ws2;
            pos_r    <= pos1;
            best_r   <= best2;
            vld_r[v] <= 1'b1;
            pend_v_r <= dec && (old != v);
            pend_a_r <= old;
            pend_d_r <= co_new;
            if (ws2 == pos_r) begin
              old_r <= v;
            end else if (leave) begin
              old_r <= hist_rd_r;
            end
          end
        end
        default: begin
          state_r <= S_ISSUE;
        end
      endcase
    end
  end

  // count table: two reads at issue, one write port shared by update and
  // the deferred decrement of the leaving byte
  always_ff @(posedge clk) begin
    if (take_real) begin
      rd0_r <= cnt_mem[q_head.byte_value];
      rd1_r <= cnt_mem[old_r];
    end
    if (upd) begin
      cnt_mem[v] <= wr_data;
    end else if (pend_v_r) begin
      cnt_mem[pend_a_r] <= pend_d_r;
    end
  end

  // history: prefetch the byte after the window start
  always_ff @(posedge clk) begin
    if (take_real) begin
      hist_mem[pos_r[lwkd_pkg::HIST_AW-1:0]] <= q_head.byte_value;
      hist_rd_r <= hist_mem[ws2_pf()];
    end
  end

endmodule
